FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLD(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed: invariant");
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: sequence");
`else
`define AST_HOLD(lbl, clk, rstn, prop)
`define AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/ppts_pkg.sv
// ---------------------------------------------------------------------------
// ppts_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ppts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int PRIO_W    = 8;
    localparam int ERR_W     = 8;
    localparam int OBJ_W     = 16;
    localparam int CMD_W     = 3;

    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SIGNAL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SIGERR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAITOBJ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SIGOBJ   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RETURN   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd7;

    localparam logic [1:0] ST_WAITING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_ACTIVE  = 2'd2;

    typedef logic [3:0] op_t;
    localparam op_t OP_NONE   = 4'd0;
    localparam op_t OP_LATCH  = 4'd1;
    localparam op_t OP_EXEC   = 4'd2;
    localparam op_t OP_CWRITE = 4'd3;
    localparam op_t OP_SERR   = 4'd4;
    localparam op_t OP_SIG    = 4'd5;
    localparam op_t OP_WAPPLY = 4'd6;
    localparam op_t OP_OSCAN  = 4'd7;
    localparam op_t OP_HSCAN  = 4'd8;
    localparam op_t OP_DECIDE = 4'd9;

    typedef struct packed {
        op_t  op;
        logic scan;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             free_found;
        logic             top_nz;
        logic             serr_ok;
        logic             scan_last;
    } sts_t;

endpackage

FILE: src/ppts_dp.sv
// ---------------------------------------------------------------------------
// ppts_dp
// Task table, ready ordering, run stack and the shared slot scan.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppts_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ppts_pkg::ctl_t              ctl,
    output ppts_pkg::sts_t              sts,
    input  logic [ppts_pkg::CMD_W-1:0]  command,
    input  logic [2:0]                  task_id,
    input  logic [7:0]                  priority_req,
    input  logic [7:0]                  error_code,
    input  logic [15:0]                 object_id,
    output logic                        dispatched,
    output logic [2:0]                  dispatch_task,
    output logic [7:0]                  dispatch_error,
    output logic [2:0]                  created_slot,
    output logic                        create_failed,
    output logic [3:0]                  ready_count,
    output logic [3:0]                  running_depth
);
    import ppts_pkg::*;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [IDX_W-1:0]  tid_reg, tid_next;
    logic [PRIO_W-1:0] prio_in_reg, prio_in_next;
    logic [ERR_W-1:0]  errc_reg, errc_next;
    logic [OBJ_W-1:0]  obj_in_reg, obj_in_next;

    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [1:0]        status_reg [MAX_TASKS];
    logic [1:0]        status_next [MAX_TASKS];
    logic [PRIO_W-1:0] prio_reg [MAX_TASKS];
    logic [PRIO_W-1:0] prio_next [MAX_TASKS];
    logic [ERR_W-1:0]  err_reg [MAX_TASKS];
    logic [ERR_W-1:0]  err_next [MAX_TASKS];
    logic [OBJ_W-1:0]  wobj_reg [MAX_TASKS];
    logic [OBJ_W-1:0]  wobj_next [MAX_TASKS];
    logic [MAX_TASKS-1:0] older_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] older_next [MAX_TASKS];
    logic [IDX_W-1:0]  stk_reg [MAX_TASKS];
    logic [IDX_W-1:0]  stk_next [MAX_TASKS];
    logic [PRIO_W-1:0] stkp_reg [MAX_TASKS];
    logic [PRIO_W-1:0] stkp_next [MAX_TASKS];

    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  rtot_reg, rtot_next;
    logic              started_reg, started_next;

    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic              best_vld_reg, best_vld_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;

    logic              did_reg, did_next;
    logic [IDX_W-1:0]  dslot_reg, dslot_next;
    logic [ERR_W-1:0]  derr_reg, derr_next;
    logic [IDX_W-1:0]  created_reg, created_next;
    logic              failed_reg, failed_next;

    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  top_m1;
    logic [IDX_W-1:0]  top_idx;
    logic [PRIO_W-1:0] cur_prio;
    logic              full;
    logic              on_stk;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              sel_used;
    logic [1:0]        sel_status;
    logic [PRIO_W-1:0] sel_prio;
    logic              do_queue;
    logic              do_disp;
    logic              cand;
    logic              scan_last;

    always_comb
    begin
        sel       = ctl.scan ? scan_reg : tgt_reg;
        top_m1    = top_reg - CNT_W'(1);
        top_idx   = top_m1[IDX_W-1:0];
        cur_prio  = (top_reg == '0) ? '0 : stkp_reg[top_idx];
        full      = (top_reg == CNT_W'(MAX_TASKS));
        scan_last = (scan_reg == IDX_W'(MAX_TASKS - 1));
        on_stk    = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if ((CNT_W'(i) < top_reg) && (stk_reg[i] == sel))
            begin
                on_stk = 1'b1;
            end
        end
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
        sel_used   = used_reg[sel];
        sel_status = status_reg[sel];
        sel_prio   = prio_reg[sel];
        cand = sel_used && (sel_status == ST_READY) &&
               (!best_vld_reg || (sel_prio > best_prio_reg) ||
                ((sel_prio == best_prio_reg) && older_reg[sel][tgt_reg]));

        do_queue = 1'b0;
        do_disp  = 1'b0;
        case (ctl.op)
            OP_SIG:
            begin
                if (sel_used)
                begin
                    if (started_reg && !on_stk && (sel_prio > cur_prio))
                    begin
                        do_disp = 1'b1;
                    end
                    else if (sel_status == ST_WAITING)
                    begin
                        do_queue = 1'b1;
                    end
                end
            end
            OP_OSCAN:
            begin
                do_queue = sel_used && (wobj_reg[sel] == obj_in_reg) &&
                           (sel_status == ST_WAITING);
            end
            OP_DECIDE:
            begin
                do_disp = !did_reg && started_reg && best_vld_reg &&
                          ((top_reg == '0) || (best_prio_reg > cur_prio));
            end
            default:
            begin
                do_queue = 1'b0;
                do_disp  = 1'b0;
            end
        endcase
        do_disp = do_disp && !full;
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        prio_in_next   = prio_in_reg;
        errc_next      = errc_reg;
        obj_in_next    = obj_in_reg;
        used_next      = used_reg;
        status_next    = status_reg;
        prio_next      = prio_reg;
        err_next       = err_reg;
        wobj_next      = wobj_reg;
        older_next     = older_reg;
        stk_next       = stk_reg;
        stkp_next      = stkp_reg;
        top_next       = top_reg;
        rtot_next      = rtot_reg;
        started_next   = started_reg;
        tgt_next       = tgt_reg;
        did_next       = did_reg;
        dslot_next     = dslot_reg;
        derr_next      = derr_reg;
        created_next   = created_reg;
        failed_next    = failed_reg;
        scan_next      = (ctl.scan && !scan_last) ? scan_reg + IDX_W'(1) : '0;
        best_vld_next  = (ctl.op == OP_HSCAN) ? best_vld_reg : 1'b0;
        best_prio_next = best_prio_reg;

        case (ctl.op)
            OP_LATCH:
            begin
                cmd_next     = command;
                tid_next     = task_id;
                prio_in_next = priority_req;
                errc_next    = error_code;
                obj_in_next  = object_id;
                did_next     = 1'b0;
                dslot_next   = '0;
                derr_next    = '0;
                created_next = '0;
                failed_next  = 1'b0;
            end
            OP_EXEC:
            begin
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        tgt_next     = free_idx;
                        created_next = free_found ? free_idx : '0;
                        failed_next  = !free_found;
                    end
                    CMD_SIGNAL, CMD_SIGERR:
                    begin
                        tgt_next = tid_reg;
                    end
                    CMD_WAIT, CMD_WAITOBJ:
                    begin
                        tgt_next = stk_reg[top_idx];
                    end
                    CMD_RETURN:
                    begin
                        if (top_reg != '0)
                        begin
                            top_next = top_m1;
                        end
                    end
                    CMD_START:
                    begin
                        started_next = 1'b1;
                    end
                    default:
                    begin
                        tgt_next = tgt_reg;
                    end
                endcase
            end
            OP_CWRITE:
            begin
                used_next[sel]   = 1'b1;
                status_next[sel] = ST_WAITING;
                prio_next[sel]   = prio_in_reg;
                err_next[sel]    = '0;
                wobj_next[sel]   = '0;
            end
            OP_SERR:
            begin
                if (sel_used && (sel_status == ST_WAITING))
                begin
                    err_next[sel] = errc_reg;
                end
            end
            OP_WAPPLY:
            begin
                if (sel_status == ST_READY)
                begin
                    rtot_next = rtot_reg - CNT_W'(1);
                end
                err_next[sel]    = '0;
                status_next[sel] = ST_WAITING;
                wobj_next[sel]   = (cmd_reg == CMD_WAITOBJ) ? obj_in_reg : '0;
            end
            OP_HSCAN:
            begin
                if (cand)
                begin
                    best_vld_next  = 1'b1;
                    best_prio_next = sel_prio;
                    tgt_next       = sel;
                end
            end
            default:
            begin
                tgt_next = tgt_reg;
            end
        endcase

        if (do_queue)
        begin
            status_next[sel] = ST_READY;
            rtot_next        = rtot_reg + CNT_W'(1);
            for (int j = 0; j < MAX_TASKS; j++)
            begin
                older_next[j][sel] = 1'b1;
            end
            older_next[sel] = '0;
        end

        if (do_disp)
        begin
            if (sel_status == ST_READY)
            begin
                rtot_next = rtot_reg - CNT_W'(1);
            end
            status_next[sel]                = ST_ACTIVE;
            wobj_next[sel]                  = '0;
            stk_next[top_reg[IDX_W-1:0]]    = sel;
            stkp_next[top_reg[IDX_W-1:0]]   = sel_prio;
            top_next                        = top_reg + CNT_W'(1);
            did_next                        = 1'b1;
            dslot_next                      = sel;
            derr_next                       = err_reg[sel];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            top_reg      <= '0;
            rtot_reg     <= '0;
            started_reg  <= 1'b0;
            scan_reg     <= '0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            top_reg      <= top_next;
            rtot_reg     <= rtot_next;
            started_reg  <= started_next;
            scan_reg     <= scan_next;
            best_vld_reg <= best_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        tid_reg       <= tid_next;
        prio_in_reg   <= prio_in_next;
        errc_reg      <= errc_next;
        obj_in_reg    <= obj_in_next;
        status_reg    <= status_next;
        prio_reg      <= prio_next;
        err_reg       <= err_next;
        wobj_reg      <= wobj_next;
        older_reg     <= older_next;
        stk_reg       <= stk_next;
        stkp_reg      <= stkp_next;
        tgt_reg       <= tgt_next;
        best_prio_reg <= best_prio_next;
        did_reg       <= did_next;
        dslot_reg     <= dslot_next;
        derr_reg      <= derr_next;
        created_reg   <= created_next;
        failed_reg    <= failed_next;
    end

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.free_found = free_found;
        sts.top_nz     = (top_reg != '0);
        sts.serr_ok    = sel_used && (sel_status == ST_WAITING);
        sts.scan_last  = scan_last;
    end

    assign dispatched     = did_reg;
    assign dispatch_task  = dslot_reg;
    assign dispatch_error = derr_reg;
    assign created_slot   = created_reg;
    assign create_failed  = failed_reg;
    assign ready_count    = rtot_reg;
    assign running_depth  = top_reg;

endmodule

FILE: src/ppts_ctrl.sv
// ---------------------------------------------------------------------------
// ppts_ctrl
// Command sequencer: steps the datapath through each command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ppts_pkg::sts_t sts,
    output ppts_pkg::ctl_t ctl,
    output logic           busy,
    output logic           done
);
    import ppts_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_CWRITE = 4'd2;
    localparam logic [3:0] S_SERR   = 4'd3;
    localparam logic [3:0] S_SIG    = 4'd4;
    localparam logic [3:0] S_WAPPLY = 4'd5;
    localparam logic [3:0] S_OSCAN  = 4'd6;
    localparam logic [3:0] S_HSCAN  = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_NONE;
        ctl.scan   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = OP_LATCH;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.op = OP_EXEC;
                case (sts.cmd)
                    CMD_CREATE:  state_next = sts.free_found ? S_CWRITE : S_HSCAN;
                    CMD_SIGNAL:  state_next = S_SIG;
                    CMD_SIGERR:  state_next = S_SERR;
                    CMD_WAIT,
                    CMD_WAITOBJ: state_next = sts.top_nz ? S_WAPPLY : S_HSCAN;
                    CMD_SIGOBJ:  state_next = S_OSCAN;
                    default:     state_next = S_HSCAN;
                endcase
            end
            S_CWRITE:
            begin
                ctl.op     = OP_CWRITE;
                state_next = S_SIG;
            end
            S_SERR:
            begin
                ctl.op     = OP_SERR;
                state_next = sts.serr_ok ? S_SIG : S_HSCAN;
            end
            S_SIG:
            begin
                ctl.op     = OP_SIG;
                state_next = S_HSCAN;
            end
            S_WAPPLY:
            begin
                ctl.op     = OP_WAPPLY;
                state_next = S_HSCAN;
            end
            S_OSCAN:
            begin
                ctl.op   = OP_OSCAN;
                ctl.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_HSCAN;
                end
            end
            S_HSCAN:
            begin
                ctl.op   = OP_HSCAN;
                ctl.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.op     = OP_DECIDE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

FILE: src/priority_preemptive_task_scheduler.sv
// ---------------------------------------------------------------------------
// priority_preemptive_task_scheduler
// Run-to-completion task scheduler: task table, priority ready order,
// nested run stack; one dispatch decision per command.
// ---------------------------------------------------------------------------
//  channel   handshake      payload
//  command   start / busy   command, task_id, priority_req, error_code,
//                           object_id
//  result    done strobe    dispatched, dispatch_task, dispatch_error,
//                           created_slot, create_failed, ready_count,
//                           running_depth
//
//  The ready-head scan over all slots runs for every command, and
//  signal_object adds a match scan over all slots ahead of it.
//  busy stays high from accept through the done cycle; start is taken only
//  when busy is low. Results show for one cycle; the receiver cannot stall.
//  Reset clears the slot-used flags, ready count, run depth and started flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module priority_preemptive_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [2:0]  task_id,
    input  logic [7:0]  priority_req,
    input  logic [7:0]  error_code,
    input  logic [15:0] object_id,
    output logic        done,
    output logic        dispatched,
    output logic [2:0]  dispatch_task,
    output logic [7:0]  dispatch_error,
    output logic [2:0]  created_slot,
    output logic        create_failed,
    output logic [3:0]  ready_count,
    output logic [3:0]  running_depth
);
    import ppts_pkg::*;

    ctl_t ctl;
    sts_t sts;

    ppts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    ppts_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .command        (command),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .error_code     (error_code),
        .object_id      (object_id),
        .dispatched     (dispatched),
        .dispatch_task  (dispatch_task),
        .dispatch_error (dispatch_error),
        .created_slot   (created_slot),
        .create_failed  (create_failed),
        .ready_count    (ready_count),
        .running_depth  (running_depth)
    );

    `AST_HOLD(a_depth_bound, clk, rst_n, running_depth <= 4'(MAX_TASKS))
    `AST_HOLD(a_ready_bound, clk, rst_n, ready_count <= 4'(MAX_TASKS))
    `AST_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `AST_NEXT(a_done_once, clk, rst_n, done, !done && !busy)

endmodule

FILE: tb/tb_priority_preemptive_task_scheduler.sv
// ---------------------------------------------------------------------------
// tb_priority_preemptive_task_scheduler
// Self-checking bench for the task scheduler. A directed list of commands and
// then weighted random commands are sent through start/busy. Each accepted
// item runs through a behavioral scheduler model. Every done strobe is checked
// field by field against the oldest predicted result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_priority_preemptive_task_scheduler;
    import ppts_pkg::*;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  tid;
        logic [7:0]  prio;
        logic [7:0]  err;
        logic [15:0] obj;
    } sched_cmd_t;

    typedef struct {
        logic       dispatched;
        logic [2:0] dtask;
        logic [7:0] derr;
        logic [2:0] cslot;
        logic       cfail;
        logic [3:0] rcount;
        logic [3:0] rdepth;
    } sched_res_t;

    localparam int NO_LINK = MAX_TASKS;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [2:0]  task_id;
    logic [7:0]  priority_req;
    logic [7:0]  error_code;
    logic [15:0] object_id;
    logic        done;
    logic        dispatched;
    logic [2:0]  dispatch_task;
    logic [7:0]  dispatch_error;
    logic [2:0]  created_slot;
    logic        create_failed;
    logic [3:0]  ready_count;
    logic [3:0]  running_depth;

    priority_preemptive_task_scheduler dut (.*);

    sched_cmd_t pending_cmds[$];
    sched_res_t expected_results[$];
    int         fail_count = 0;
    int         sent_count = 0;

    // scheduler model state
    logic        m_used   [MAX_TASKS];
    logic [1:0]  m_status [MAX_TASKS];
    logic [7:0]  m_prio   [MAX_TASKS];
    logic [7:0]  m_err    [MAX_TASKS];
    logic [15:0] m_wobj   [MAX_TASKS];
    int          m_link   [MAX_TASKS];
    int          m_stack  [MAX_TASKS];
    int          m_head;
    int          m_total;
    int          m_top;
    logic        m_started;
    sched_res_t  m_res;

    function automatic bit running(int t);
        for (int i = 0; i < m_top; i++)
            if (m_stack[i] == t)
                return 1;
        return 0;
    endfunction

    function automatic int cur_prio();
        if (m_top == 0)
            return 0;
        return m_prio[m_stack[m_top-1]];
    endfunction

    function automatic void ready_insert(int t);
        int prev;
        int itr;
        prev = NO_LINK;
        itr = m_head;
        while (itr < MAX_TASKS && m_prio[itr] >= m_prio[t]) begin
            prev = itr;
            itr = m_link[itr];
        end
        m_link[t] = itr;
        if (prev == NO_LINK)
            m_head = t;
        else
            m_link[prev] = t;
        m_total++;
    endfunction

    function automatic void ready_remove(int t);
        int prev;
        int itr;
        prev = NO_LINK;
        itr = m_head;
        while (itr < MAX_TASKS) begin
            if (itr == t) begin
                if (prev == NO_LINK)
                    m_head = m_link[itr];
                else
                    m_link[prev] = m_link[itr];
                m_link[itr] = NO_LINK;
                if (m_total > 0)
                    m_total--;
                return;
            end
            prev = itr;
            itr = m_link[itr];
        end
    endfunction

    function automatic void make_ready(int t);
        if (!m_used[t] || m_status[t] != ST_WAITING)
            return;
        m_status[t] = ST_READY;
        ready_insert(t);
    endfunction

    function automatic void run_task(int t);
        if (m_top >= MAX_TASKS)
            return;
        if (m_status[t] == ST_READY)
            ready_remove(t);
        m_status[t] = ST_ACTIVE;
        m_wobj[t] = '0;
        m_stack[m_top] = t;
        m_top++;
        m_res.dispatched = 1'b1;
        m_res.dtask = t[2:0];
        m_res.derr = m_err[t];
    endfunction

    function automatic void wake_task(int t);
        if (!m_used[t])
            return;
        if (m_started && !running(t) && int'(m_prio[t]) > cur_prio())
            run_task(t);
        else
            make_ready(t);
    endfunction

    function automatic void block_current(logic [15:0] obj);
        int t;
        if (m_top == 0)
            return;
        t = m_stack[m_top-1];
        if (m_status[t] == ST_READY)
            ready_remove(t);
        m_err[t] = '0;
        m_status[t] = ST_WAITING;
        m_wobj[t] = obj;
    endfunction

    function automatic sched_res_t schedule_command(sched_cmd_t c);
        int slot;
        m_res = '{default: '0};
        case (c.cmd)
            CMD_CREATE: begin
                slot = MAX_TASKS;
                for (int i = MAX_TASKS - 1; i >= 0; i--)
                    if (!m_used[i])
                        slot = i;
                if (slot < MAX_TASKS) begin
                    m_used[slot] = 1'b1;
                    m_status[slot] = ST_WAITING;
                    m_prio[slot] = c.prio;
                    m_err[slot] = '0;
                    m_wobj[slot] = '0;
                    m_link[slot] = NO_LINK;
                    m_res.cslot = slot[2:0];
                    wake_task(slot);
                end
                else
                    m_res.cfail = 1'b1;
            end
            CMD_SIGNAL: wake_task(c.tid);
            CMD_SIGERR: begin
                if (m_used[c.tid] && m_status[c.tid] == ST_WAITING) begin
                    m_err[c.tid] = c.err;
                    wake_task(c.tid);
                end
            end
            CMD_WAIT:    block_current('0);
            CMD_WAITOBJ: block_current(c.obj);
            CMD_SIGOBJ: begin
                for (int i = 0; i < MAX_TASKS; i++)
                    if (m_used[i] && m_wobj[i] == c.obj)
                        make_ready(i);
            end
            CMD_RETURN: begin
                if (m_top > 0)
                    m_top--;
            end
            default: m_started = 1'b1;
        endcase
        if (!m_res.dispatched && m_started && m_head < MAX_TASKS
            && (m_top == 0 || int'(m_prio[m_head]) > cur_prio()))
            run_task(m_head);
        m_res.rcount = m_total[3:0];
        m_res.rdepth = m_top[3:0];
        return m_res;
    endfunction

    function automatic sched_cmd_t mk_cmd(logic [2:0] cmd, logic [2:0] tid, logic [7:0] prio,
                                          logic [7:0] err, logic [15:0] obj);
        sched_cmd_t c;
        c.cmd = cmd;
        c.tid = tid;
        c.prio = prio;
        c.err = err;
        c.obj = obj;
        return c;
    endfunction

    function automatic logic [15:0] pick_object();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return CMD_CREATE;
        if (r < 28) return CMD_SIGNAL;
        if (r < 42) return CMD_SIGERR;
        if (r < 54) return CMD_WAIT;
        if (r < 66) return CMD_WAITOBJ;
        if (r < 80) return CMD_SIGOBJ;
        if (r < 95) return CMD_RETURN;
        return CMD_START;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            m_used[i] = 1'b0;
            m_link[i] = NO_LINK;
        end
        m_head = NO_LINK;
        m_total = 0;
        m_top = 0;
        m_started = 1'b0;

        // before start: no dispatch, tasks queue up
        pending_cmds.push_back(mk_cmd(CMD_RETURN, 3'd0, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_WAIT, 3'd0, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_SIGNAL, 3'd7, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd7, 8'd0, 8'hFF, 16'hFFFF));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd255, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd255, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_START, 3'd0, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_WAITOBJ, 3'd0, 8'd0, 8'd0, 16'hFFFF));
        pending_cmds.push_back(mk_cmd(CMD_SIGERR, 3'd1, 8'd0, 8'd255, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_SIGOBJ, 3'd0, 8'd0, 8'd0, 16'hFFFF));
        pending_cmds.push_back(mk_cmd(CMD_WAIT, 3'd0, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_SIGOBJ, 3'd0, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd128, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd1, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_RETURN, 3'd0, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd200, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd200, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd7, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd9, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_CREATE, 3'd0, 8'd50, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_SIGNAL, 3'd2, 8'd0, 8'd0, 16'd0));
        pending_cmds.push_back(mk_cmd(CMD_SIGERR, 3'd5, 8'd0, 8'd0, 16'd0));
        for (int i = 0; i < 1700; i++)
            pending_cmds.push_back(mk_cmd(pick_command(), 3'($urandom), 8'($urandom),
                                          8'($urandom), pick_object()));

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            command      <= '0;
            task_id      <= '0;
            priority_req <= '0;
            error_code   <= '0;
            object_id    <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(schedule_command(mk_cmd(command, task_id,
                    priority_req, error_code, object_id)));
            if (!(start && busy))
            begin
                if (pending_cmds.size() != 0
                    && ((sent_count > 700 && sent_count < 1000) || $urandom_range(99) >= 33))
                begin
                    sched_cmd_t c;
                    c = pending_cmds.pop_front();
                    sent_count <= sent_count + 1;
                    start        <= 1'b1;
                    command      <= c.cmd;
                    task_id      <= c.tid;
                    priority_req <= c.prio;
                    error_code   <= c.err;
                    object_id    <= c.obj;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with none expected");
                fail_count++;
            end
            else
            begin
                sched_res_t e;
                e = expected_results.pop_front();
                if (dispatched !== e.dispatched)
                begin
                    $error("dispatched exp %0d got %0d", e.dispatched, dispatched);
                    fail_count++;
                end
                if (dispatch_task !== e.dtask)
                begin
                    $error("dispatch_task exp %0d got %0d", e.dtask, dispatch_task);
                    fail_count++;
                end
                if (dispatch_error !== e.derr)
                begin
                    $error("dispatch_error exp %0d got %0d", e.derr, dispatch_error);
                    fail_count++;
                end
                if (created_slot !== e.cslot)
                begin
                    $error("created_slot exp %0d got %0d", e.cslot, created_slot);
                    fail_count++;
                end
                if (create_failed !== e.cfail)
                begin
                    $error("create_failed exp %0d got %0d", e.cfail, create_failed);
                    fail_count++;
                end
                if (ready_count !== e.rcount)
                begin
                    $error("ready_count exp %0d got %0d", e.rcount, ready_count);
                    fail_count++;
                end
                if (running_depth !== e.rdepth)
                begin
                    $error("running_depth exp %0d got %0d", e.rdepth, running_depth);
                    fail_count++;
                end
            end
        end
    end

endmodule
